/* rtl/bfd_pkg.sv */
// Package for the bearing block: constants, payload types and the CORDIC angle table.
package bfd_pkg;

    localparam int CoordWidth   = 24;
    localparam int DiffWidth    = CoordWidth + 1;
    localparam int XyWidth      = 28;
    localparam int ZWidth       = 26;
    localparam int BearingWidth = 17;
    localparam int InDataWidth  = 4 * CoordWidth;
    localparam int OutDataWidth = ((BearingWidth + 7) / 8) * 8;
    localparam int DefaultIterations = 16;

    // Fixed bearings in 1/256 degree
    localparam logic [BearingWidth-1:0] Bearing0   = 17'd0;
    localparam logic [BearingWidth-1:0] Bearing90  = 17'd23040;
    localparam logic [BearingWidth-1:0] Bearing180 = 17'd46080;
    localparam logic [BearingWidth-1:0] Bearing270 = 17'd69120;
    localparam logic [BearingWidth-1:0] Bearing360 = 17'd92160;

    // 90 degrees in angle-accumulator units of 2^-16 degree
    localparam logic signed [ZWidth-1:0] Deg90Z = 26'sd5898240;
    localparam logic signed [ZWidth-1:0] ZRound = 26'sd128;

    // Quadrant and fixed-result information that rides along the chain
    typedef struct packed {
        logic                    fixed_sel;
        logic [BearingWidth-1:0] fixed_bearing;
        logic                    dx_neg;
        logic                    same_sign;
    } side_t;

    // One vector in flight through the rotation chain
    typedef struct packed {
        logic signed [XyWidth-1:0] x;
        logic signed [XyWidth-1:0] y;
        logic signed [ZWidth-1:0]  z;
        side_t                     side;
    } vec_t;

    // round(atan(2^-i) in degrees * 65536)
    function automatic logic signed [ZWidth-1:0] atan_entry(input logic [4:0] idx);
        logic signed [ZWidth-1:0] val;
        case (idx)
            5'd0:    val = 26'sd2949120;
            5'd1:    val = 26'sd1740967;
            5'd2:    val = 26'sd919879;
            5'd3:    val = 26'sd466945;
            5'd4:    val = 26'sd234379;
            5'd5:    val = 26'sd117304;
            5'd6:    val = 26'sd58666;
            5'd7:    val = 26'sd29335;
            5'd8:    val = 26'sd14668;
            5'd9:    val = 26'sd7334;
            5'd10:   val = 26'sd3667;
            5'd11:   val = 26'sd1833;
            5'd12:   val = 26'sd917;
            5'd13:   val = 26'sd458;
            5'd14:   val = 26'sd229;
            5'd15:   val = 26'sd115;
            5'd16:   val = 26'sd57;
            5'd17:   val = 26'sd29;
            5'd18:   val = 26'sd14;
            5'd19:   val = 26'sd7;
            5'd20:   val = 26'sd4;
            5'd21:   val = 26'sd2;
            5'd22:   val = 26'sd1;
            default: val = 26'sd0;
        endcase
        return val;
    endfunction

endpackage

/* rtl/bfd_prep.sv */
// Input stage: forms the displacement, its magnitudes, quadrant flags and fixed bearings.
module bfd_prep (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [bfd_pkg::InDataWidth-1:0]    in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output bfd_pkg::vec_t                      out_vec
);

    logic                                  valid_reg;
    logic                                  valid_next;
    bfd_pkg::vec_t                         vec_reg;
    bfd_pkg::vec_t                         vec_next;
    logic signed [bfd_pkg::DiffWidth-1:0]  dx;
    logic signed [bfd_pkg::DiffWidth-1:0]  dy;
    logic signed [bfd_pkg::DiffWidth-1:0]  abs_dx;
    logic signed [bfd_pkg::DiffWidth-1:0]  abs_dy;
    logic                                  dx_zero;
    logic                                  dy_zero;

    // Take a new transfer when empty or when the next cell moves on
    assign in_ready = !valid_reg || out_ready;

    // Sign-extend and subtract the coordinates
    always_comb
    begin
        dx = $signed({in_data[23], in_data[23:0]}) - $signed({in_data[71], in_data[71:48]});
        dy = $signed({in_data[47], in_data[47:24]}) - $signed({in_data[95], in_data[95:72]});
        abs_dx = dx[bfd_pkg::DiffWidth-1] ? -dx : dx;
        abs_dy = dy[bfd_pkg::DiffWidth-1] ? -dy : dy;
        dx_zero = (dx == '0);
        dy_zero = (dy == '0);
    end

    // Build the starting vector and the side information
    always_comb
    begin
        vec_next.x = $signed({{(bfd_pkg::XyWidth-bfd_pkg::DiffWidth){1'b0}}, abs_dx});
        vec_next.y = $signed({{(bfd_pkg::XyWidth-bfd_pkg::DiffWidth){1'b0}}, abs_dy});
        vec_next.z = '0;
        vec_next.side.dx_neg    = dx[bfd_pkg::DiffWidth-1];
        vec_next.side.same_sign = (dx[bfd_pkg::DiffWidth-1] == dy[bfd_pkg::DiffWidth-1]);
        vec_next.side.fixed_sel = dx_zero || dy_zero;
        if (dx_zero && !dy_zero && !dy[bfd_pkg::DiffWidth-1])
            vec_next.side.fixed_bearing = bfd_pkg::Bearing180;
        else if (dx_zero && !dy_zero)
            vec_next.side.fixed_bearing = bfd_pkg::Bearing0;
        else if (dy_zero && !dx_zero && !dx[bfd_pkg::DiffWidth-1])
            vec_next.side.fixed_bearing = bfd_pkg::Bearing90;
        else
            vec_next.side.fixed_bearing = bfd_pkg::Bearing270;
    end

    // Hold or advance the valid flag
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Load the payload on an accepted transfer
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            vec_reg <= vec_next;
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

endmodule

/* rtl/bfd_cell.sv */
// One CORDIC vectoring cell: a single micro-rotation with its own output register.
module bfd_cell #(
    parameter int SHIFT = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  bfd_pkg::vec_t  in_vec,
    output logic           out_valid,
    input  logic           out_ready,
    output bfd_pkg::vec_t  out_vec
);

    logic                                 valid_reg;
    logic                                 valid_next;
    bfd_pkg::vec_t                        vec_reg;
    bfd_pkg::vec_t                        vec_next;
    logic signed [bfd_pkg::XyWidth-1:0]   xs;
    logic signed [bfd_pkg::XyWidth-1:0]   ys;
    logic signed [bfd_pkg::ZWidth-1:0]    step_angle;

    assign in_ready   = !valid_reg || out_ready;
    assign step_angle = bfd_pkg::atan_entry(5'(SHIFT));

    // Rotate toward the x axis by the sign of y
    always_comb
    begin
        xs = in_vec.x >>> SHIFT;
        ys = in_vec.y >>> SHIFT;
        vec_next.side = in_vec.side;
        if (!in_vec.y[bfd_pkg::XyWidth-1])
        begin
            vec_next.x = in_vec.x + ys;
            vec_next.y = in_vec.y - xs;
            vec_next.z = in_vec.z + step_angle;
        end
        else
        begin
            vec_next.x = in_vec.x - ys;
            vec_next.y = in_vec.y + xs;
            vec_next.z = in_vec.z - step_angle;
        end
    end

    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            vec_reg <= vec_next;
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

endmodule

/* rtl/bfd_post.sv */
// Output stage: clamps and rounds the angle, places it in its quadrant, holds the result.
module bfd_post (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  bfd_pkg::vec_t                       in_vec,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [bfd_pkg::BearingWidth-1:0]    bearing
);

    logic                                   valid_reg;
    logic                                   valid_next;
    logic [bfd_pkg::BearingWidth-1:0]       bearing_reg;
    logic [bfd_pkg::BearingWidth-1:0]       bearing_next;
    logic signed [bfd_pkg::ZWidth-1:0]      z_clamp;
    logic signed [bfd_pkg::ZWidth-1:0]      z_round;
    logic [bfd_pkg::BearingWidth-1:0]       theta;
    logic [bfd_pkg::BearingWidth-1:0]       base;
    logic [bfd_pkg::BearingWidth-1:0]       sum;

    assign in_ready = !valid_reg || out_ready;

    // Clamp to 0..90 degrees and round to 1/256 degree, ties upward
    always_comb
    begin
        if (in_vec.z[bfd_pkg::ZWidth-1])
            z_clamp = '0;
        else if (in_vec.z > bfd_pkg::Deg90Z)
            z_clamp = bfd_pkg::Deg90Z;
        else
            z_clamp = in_vec.z;
        z_round = z_clamp + bfd_pkg::ZRound;
        theta   = bfd_pkg::BearingWidth'(z_round[bfd_pkg::ZWidth-1:8]);
    end

    // Offset from the 90 or 270 degree base, or take the fixed bearing; wrap a full circle to zero
    always_comb
    begin
        base = in_vec.side.dx_neg ? bfd_pkg::Bearing270 : bfd_pkg::Bearing90;
        sum  = in_vec.side.same_sign ? (base + theta) : (base - theta);
        if (in_vec.side.fixed_sel)
            bearing_next = in_vec.side.fixed_bearing;
        else if (sum >= bfd_pkg::Bearing360)
            bearing_next = sum - bfd_pkg::Bearing360;
        else
            bearing_next = sum;
    end

    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            bearing_reg <= bearing_next;
    end

    assign out_valid = valid_reg;
    assign bearing   = bearing_reg;

endmodule

/* rtl/bearing_from_displacement_top.sv */
// Registers from input transfer to result: bfd_prep, each rotation cell, then bfd_post.
// Throughput: one item per cycle while the output is not stalled; each rotation cell holds one vector and passes it on.
// Every stage has its own valid register, so bubbles close up and input is taken while
// a result waits at the output, as long as some stage is still empty.
// Reset: rst_n asynchronously clears all valid flags; payload registers are not reset.
module bearing_from_displacement_top #(
    parameter int CORDIC_ITERATIONS = bfd_pkg::DefaultIterations
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // point_a_x [23:0], point_a_y [47:24], point_b_x [71:48], point_b_y [95:72]
    input  logic [bfd_pkg::InDataWidth-1:0]      s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // bearing [16:0], zero fill [23:17]
    output logic [bfd_pkg::OutDataWidth-1:0]     m_axis_tdata
);

    logic                              stage_valid [0:CORDIC_ITERATIONS];
    logic                              stage_ready [0:CORDIC_ITERATIONS];
    bfd_pkg::vec_t                     stage_vec   [0:CORDIC_ITERATIONS];
    logic [bfd_pkg::BearingWidth-1:0]  bearing;

    // Displacement and magnitudes
    bfd_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .out_valid (stage_valid[0]),
        .out_ready (stage_ready[0]),
        .out_vec   (stage_vec[0])
    );

    // Chain of rotation cells
    for (genvar k = 0; k < CORDIC_ITERATIONS; k++)
    begin : g_cell
        bfd_cell #(
            .SHIFT (k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[k]),
            .in_ready  (stage_ready[k]),
            .in_vec    (stage_vec[k]),
            .out_valid (stage_valid[k+1]),
            .out_ready (stage_ready[k+1]),
            .out_vec   (stage_vec[k+1])
        );
    end

    // Rounding, quadrant placement and output register
    bfd_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stage_valid[CORDIC_ITERATIONS]),
        .in_ready  (stage_ready[CORDIC_ITERATIONS]),
        .in_vec    (stage_vec[CORDIC_ITERATIONS]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .bearing   (bearing)
    );

    assign m_axis_tdata = {{(bfd_pkg::OutDataWidth-bfd_pkg::BearingWidth){1'b0}}, bearing};

endmodule

/* rtl/bfd_checker.sv */
// Port-level checks for the bearing block and their bind to the top level.
module bfd_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tready,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [bfd_pkg::OutDataWidth-1:0]  m_axis_tdata
);

    // A result stays put while the sink stalls
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Bearing stays below a full circle
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[bfd_pkg::BearingWidth-1:0] < bfd_pkg::Bearing360)
        else $error("bearing out of range");

    // Fill bits above the bearing are zero
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[bfd_pkg::OutDataWidth-1:bfd_pkg::BearingWidth] == '0)
        else $error("nonzero fill bits");

    // A free output side means the chain drains, so input is taken
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tready || !m_axis_tvalid) |-> s_axis_tready)
        else $error("input stalled with free output");

    // Nothing leaves in the cycle after a fresh reset release
    a_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_axis_tvalid)
        else $error("result valid out of reset");

endmodule

bind bearing_from_displacement_top bfd_checker u_bfd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* tb/tb_bearing_from_displacement_top.sv */
// Testbench for the bearing block: directed table plus random pairs against a CORDIC predictor.
module tb_bearing_from_displacement_top;

    localparam int RotSteps   = bfd_pkg::DefaultIterations;
    localparam int Latency    = RotSteps + 2;
    localparam int RandItems  = 1727;
    localparam int QuietTail  = 250;
    localparam int CycleLimit = 200000;

    localparam logic [bfd_pkg::CoordWidth-1:0] CoordMax = 24'h7FFFFF;
    localparam logic [bfd_pkg::CoordWidth-1:0] CoordMin = 24'h800000;

    // One row of the directed table
    typedef struct {
        logic [bfd_pkg::CoordWidth-1:0]   ax;
        logic [bfd_pkg::CoordWidth-1:0]   ay;
        logic [bfd_pkg::CoordWidth-1:0]   bx;
        logic [bfd_pkg::CoordWidth-1:0]   by;
        bit                               typed;
        logic [bfd_pkg::BearingWidth-1:0] bearing;
    } probe_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [bfd_pkg::InDataWidth-1:0]  s_axis_tdata = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [bfd_pkg::OutDataWidth-1:0] m_axis_tdata;

    // Arc step per rotation in 2^-16 degree
    longint arc_step [0:31] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0,
        0, 0, 0, 0, 0, 0, 0, 0
    };

    logic [bfd_pkg::BearingWidth-1:0] pending_bearings [$];
    probe_t                           probe_tab [$];

    bit                               drv_typed = 1'b0;
    logic [bfd_pkg::BearingWidth-1:0] drv_typed_bearing = '0;
    bit                               idle_on = 1'b1;
    int                               rx_stall_left = 0;
    int                               fail_count = 0;
    int                               items_sent = 0;
    int                               results_seen = 0;
    int                               axis_hits = 0;
    int                               wrap_hits = 0;
    int                               cycle_count = 0;

    bearing_from_displacement_top #(
        .CORDIC_ITERATIONS(RotSteps)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #1 clk = ~clk;

    // Bearing of point a minus point b, in 1/256 degree
    function automatic logic [bfd_pkg::BearingWidth-1:0] predict_bearing(
        input logic signed [bfd_pkg::CoordWidth-1:0] ax,
        input logic signed [bfd_pkg::CoordWidth-1:0] ay,
        input logic signed [bfd_pkg::CoordWidth-1:0] bx,
        input logic signed [bfd_pkg::CoordWidth-1:0] by
    );
        longint dx;
        longint dy;
        longint vx;
        longint vy;
        longint ang;
        longint sx;
        longint sy;
        longint theta;
        longint res;
        dx = longint'(ax) - longint'(bx);
        dy = longint'(ay) - longint'(by);
        if (dx != 0 && dy != 0)
        begin
            vx = (dx < 0) ? -dx : dx;
            vy = (dy < 0) ? -dy : dy;
            ang = 0;
            // rotate toward the x axis, tracking the angle
            for (int k = 0; k < RotSteps && k < 32; k++)
            begin
                sx = vx >>> k;
                sy = vy >>> k;
                if (vy >= 0)
                begin
                    vx = vx + sy;
                    vy = vy - sx;
                    ang = ang + arc_step[k];
                end
                else
                begin
                    vx = vx - sy;
                    vy = vy + sx;
                    ang = ang - arc_step[k];
                end
            end
            if (ang < 0)
                ang = 0;
            if (ang > 90 * 65536)
                ang = 90 * 65536;
            theta = (ang + 128) >>> 8;
            res = (dx > 0) ? 23040 : 69120;
            res = ((dx > 0) == (dy > 0)) ? res + theta : res - theta;
            if (res >= 92160)
                res = res - 92160;
        end
        else if (dx == 0 && dy > 0)
            res = 46080;
        else if (dx == 0 && dy < 0)
            res = 0;
        else if (dy == 0 && dx > 0)
            res = 23040;
        else
            res = 69120;
        return res[bfd_pkg::BearingWidth-1:0];
    endfunction

    function automatic logic [bfd_pkg::CoordWidth-1:0] corner_coord();
        case ($urandom_range(0, 5))
            0: return CoordMax;
            1: return CoordMin;
            2: return 24'h000000;
            3: return 24'hFFFFFF;
            4: return 24'h000001;
            default: return 24'h7FFFFE;
        endcase
    endfunction

    task automatic add_probe(
        input logic [bfd_pkg::CoordWidth-1:0] ax,
        input logic [bfd_pkg::CoordWidth-1:0] ay,
        input logic [bfd_pkg::CoordWidth-1:0] bx,
        input logic [bfd_pkg::CoordWidth-1:0] by,
        input bit typed,
        input logic [bfd_pkg::BearingWidth-1:0] bearing
    );
        probe_t row;
        row.ax = ax;
        row.ay = ay;
        row.bx = bx;
        row.by = by;
        row.typed = typed;
        row.bearing = bearing;
        probe_tab.push_back(row);
    endtask

    // Present one point pair and hold it until the transfer; returns at a falling edge
    task automatic send_pair(
        input logic [bfd_pkg::CoordWidth-1:0] ax,
        input logic [bfd_pkg::CoordWidth-1:0] ay,
        input logic [bfd_pkg::CoordWidth-1:0] bx,
        input logic [bfd_pkg::CoordWidth-1:0] by,
        input bit typed,
        input logic [bfd_pkg::BearingWidth-1:0] bearing
    );
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= {$urandom, $urandom, $urandom};
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        s_axis_tdata <= {by, bx, ay, ax};
        s_axis_tvalid <= 1'b1;
        drv_typed = typed;
        drv_typed_bearing = bearing;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    // Random point pair, weighted toward axes, coincident points, corners, short displacements and steep slopes
    task automatic send_random_pair();
        logic [bfd_pkg::CoordWidth-1:0] ax;
        logic [bfd_pkg::CoordWidth-1:0] ay;
        logic [bfd_pkg::CoordWidth-1:0] bx;
        logic [bfd_pkg::CoordWidth-1:0] by;
        logic [bfd_pkg::CoordWidth-1:0] delta;
        int kind;
        ax = $urandom;
        ay = $urandom;
        bx = $urandom;
        by = $urandom;
        kind = $urandom_range(0, 9);
        case (kind)
            4: bx = ax;
            5: by = ay;
            6:
            begin
                bx = ax;
                by = ay;
            end
            7:
            begin
                bx = ax - bfd_pkg::CoordWidth'($urandom_range(0, 16)) + 24'd8;
                by = ay - bfd_pkg::CoordWidth'($urandom_range(0, 16)) + 24'd8;
            end
            8:
            begin
                ax = corner_coord();
                ay = corner_coord();
                bx = corner_coord();
                by = corner_coord();
            end
            9:
            begin
                delta = bfd_pkg::CoordWidth'($urandom_range(0, 6)) - 24'd3;
                if ($urandom_range(0, 1))
                    bx = ax - delta;
                else
                    by = ay - delta;
            end
            default: ;
        endcase
        send_pair(ax, ay, bx, by, 1'b0, '0);
    endtask

    // Drop the result-side ready in random bursts while idles are enabled
    always @(negedge clk)
    begin
        if (rx_stall_left != 0)
        begin
            rx_stall_left <= rx_stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            rx_stall_left <= $urandom_range(0, 4);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Record expectations on input transfers, check output transfers
    always @(posedge clk)
    begin
        logic [bfd_pkg::BearingWidth-1:0] want;
        logic [bfd_pkg::BearingWidth-1:0] got;
        logic [bfd_pkg::CoordWidth-1:0]   dx;
        logic [bfd_pkg::CoordWidth-1:0]   dy;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            got = m_axis_tdata[bfd_pkg::BearingWidth-1:0];
            if (pending_bearings.size() == 0)
            begin
                $error("bearing: no result expected, actual %0d", got);
                fail_count++;
            end
            else
            begin
                want = pending_bearings.pop_front();
                if (got !== want)
                begin
                    $error("bearing: expected %0d, actual %0d", want, got);
                    fail_count++;
                end
            end
            if (m_axis_tdata[bfd_pkg::OutDataWidth-1:bfd_pkg::BearingWidth] !== '0)
            begin
                $error("zero fill: expected 0, actual %0h",
                       m_axis_tdata[bfd_pkg::OutDataWidth-1:bfd_pkg::BearingWidth]);
                fail_count++;
            end
        end
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            items_sent++;
            want = predict_bearing(s_axis_tdata[23:0], s_axis_tdata[47:24],
                                   s_axis_tdata[71:48], s_axis_tdata[95:72]);
            dx = s_axis_tdata[23:0] - s_axis_tdata[71:48];
            dy = s_axis_tdata[47:24] - s_axis_tdata[95:72];
            if (dx == '0 || dy == '0)
                axis_hits++;
            else if (want == bfd_pkg::Bearing0)
                wrap_hits++;
            pending_bearings.push_back(drv_typed ? drv_typed_bearing : want);
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        // axes, both-zero and full-range extremes have fixed answers
        add_probe(24'd0, 24'd0, 24'd0, 24'd0, 1'b1, bfd_pkg::Bearing270);
        add_probe(CoordMax, CoordMin, CoordMax, CoordMin, 1'b1, bfd_pkg::Bearing270);
        add_probe(24'd5, CoordMax, 24'd5, CoordMin, 1'b1, bfd_pkg::Bearing180);
        add_probe(CoordMin, CoordMin, CoordMin, CoordMax, 1'b1, bfd_pkg::Bearing0);
        add_probe(24'd0, 24'd1, 24'd0, 24'd0, 1'b1, bfd_pkg::Bearing180);
        add_probe(24'd0, 24'd0, 24'd0, 24'd1, 1'b1, bfd_pkg::Bearing0);
        add_probe(CoordMax, 24'd3, CoordMin, 24'd3, 1'b1, bfd_pkg::Bearing90);
        add_probe(CoordMin, 24'd3, CoordMax, 24'd3, 1'b1, bfd_pkg::Bearing270);
        add_probe(24'd1, 24'd9, 24'd0, 24'd9, 1'b1, bfd_pkg::Bearing90);
        add_probe(24'd0, 24'd9, 24'd1, 24'd9, 1'b1, bfd_pkg::Bearing270);
        // diagonals in each quadrant, largest spans, near each axis and the wrap
        add_probe(24'd1, 24'd1, 24'd0, 24'd0, 1'b0, '0);
        add_probe(24'd1, 24'd0, 24'd0, 24'd1, 1'b0, '0);
        add_probe(24'd0, 24'd1, 24'd1, 24'd0, 1'b0, '0);
        add_probe(24'd0, 24'd0, 24'd1, 24'd1, 1'b0, '0);
        add_probe(CoordMax, CoordMax, CoordMin, CoordMin, 1'b0, '0);
        add_probe(CoordMin, CoordMin, CoordMax, CoordMax, 1'b0, '0);
        add_probe(CoordMax, CoordMin, CoordMin, CoordMax, 1'b0, '0);
        add_probe(CoordMin, CoordMax, CoordMax, CoordMin, 1'b0, '0);
        add_probe(24'd0, CoordMin, 24'd1, CoordMax, 1'b0, '0);
        add_probe(24'd1, CoordMax, 24'd0, CoordMin, 1'b0, '0);
        add_probe(CoordMax, 24'd1, CoordMin, 24'd0, 1'b0, '0);
        add_probe(CoordMin, 24'd0, CoordMax, 24'd1, 1'b0, '0);
        add_probe(24'd1, CoordMin, 24'd0, CoordMax, 1'b0, '0);

        // hold reset, then release it on a falling edge
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        foreach (probe_tab[n])
            send_pair(probe_tab[n].ax, probe_tab[n].ay, probe_tab[n].bx, probe_tab[n].by,
                      probe_tab[n].typed, probe_tab[n].bearing);

        // drain the pipe completely before the random part
        s_axis_tvalid <= 1'b0;
        while (pending_bearings.size() != 0)
            @(negedge clk);

        for (int n = 0; n < RandItems; n++)
        begin
            if (n >= RandItems - QuietTail)
                idle_on = 1'b0;
            else if (n % 100 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            if (n == RandItems / 2)
            begin
                s_axis_tvalid <= 1'b0;
                while (pending_bearings.size() != 0)
                    @(negedge clk);
            end
            send_random_pair();
        end
        s_axis_tvalid <= 1'b0;

        // wait for the tail, then watch for stray results
        while (pending_bearings.size() != 0)
            @(posedge clk);
        repeat (Latency + 8) @(posedge clk);

        $display("covered %0d point pairs, %0d results: %0d on an axis or coincident,",
                 items_sent, results_seen, axis_hits);
        $display("%0d wrapped past 360 degrees, in %0d cycles with random stalls on both sides",
                 wrap_hits, cycle_count);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
